// ===== sv/bmpblit_pkg.sv =====
// Shared types, constants and helpers of the BMP to framebuffer blit unit.
`timescale 1ns / 1ps

package bmpblit_pkg;

    localparam int SCREEN_WIDTH_DEF  = 800;
    localparam int SCREEN_HEIGHT_DEF = 600;
    localparam int QUEUE_DEPTH       = 2;

    localparam int DIM_W   = 10;
    localparam int PAD_W   = 2;
    localparam int ADDR_W  = 19;
    localparam int WORD_W  = 24;
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 2;

    localparam logic [DIM_W-1:0] WIDTH_RST   = 10'd800;
    localparam logic [DIM_W-1:0] HEIGHT_RST  = 10'd600;
    localparam logic [PAD_W-1:0] PADDING_RST = 2'd0;

    localparam logic [INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [INDEX_W-1:0] REG_ROW_PADDING  = 2'd2;

    typedef enum logic [1:0] {
        PH_BLUE  = 2'd0,
        PH_GREEN = 2'd1,
        PH_RED   = 2'd2
    } t_phase;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [PAD_W-1:0] padding;
    } t_geom;

    typedef struct packed {
        logic [DIM_W-1:0]  rows_left;
        logic [DIM_W-1:0]  column;
        logic [WORD_W-1:0] word;
        logic              last;
    } t_pixel;

    function automatic logic [DIM_W-1:0] f_clamp(input logic [DIM_W-1:0] value,
                                                 input int limit);
        logic [DIM_W-1:0] result;
        result = value;
        if (value == '0) begin
            result = 10'd1;
        end else if (int'(value) > limit) begin
            result = DIM_W'(limit);
        end
        return result;
    endfunction

endpackage

// ===== sv/bmpblit_queue.sv =====
// Short pixel queue between the byte classifier and the address stage.
`timescale 1ns / 1ps

module bmpblit_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  bmpblit_pkg::t_pixel  i_entry,
    input  logic                 i_pop,
    output bmpblit_pkg::t_pixel  o_entry,
    output logic                 o_full,
    output logic                 o_empty
);

    localparam int DEPTH = bmpblit_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bmpblit_pkg::t_pixel r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    assign o_entry = r_mem[r_rd];
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("Queue holds more items than its depth.");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("Queue popped while empty.");

endmodule

// ===== sv/bmpblit_front.sv =====
// Byte classifier: frame counters, padding skip and BGR byte grouping.
`timescale 1ns / 1ps

module bmpblit_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic [bmpblit_pkg::BYTE_W-1:0]      i_data_byte,
    input  logic                                i_frame_start,
    input  logic                                i_restart,
    input  bmpblit_pkg::t_geom                  i_geom,
    output logic                                o_emit,
    output bmpblit_pkg::t_pixel                 o_pixel
);

    localparam int DIM_W = bmpblit_pkg::DIM_W;
    localparam int PAD_W = bmpblit_pkg::PAD_W;

    bmpblit_pkg::t_phase r_phase, n_phase, e_phase;
    logic [15:0]      r_bg, n_bg;
    logic [DIM_W-1:0] r_col, n_col, e_col;
    logic [DIM_W-1:0] r_rows, n_rows, e_rows;
    logic [PAD_W-1:0] r_pad, n_pad, e_pad;
    logic             r_done, n_done, e_done;
    logic             r_pend, n_pend;

    logic             e_rs;
    logic [DIM_W-1:0] col_inc;
    logic [DIM_W-1:0] rows_dec;
    logic [DIM_W:0]   col_sum;

    assign e_rs     = r_pend || (i_accept && i_frame_start);
    assign e_phase  = e_rs ? bmpblit_pkg::PH_BLUE : r_phase;
    assign e_col    = e_rs ? '0 : r_col;
    assign e_pad    = e_rs ? '0 : r_pad;
    assign e_done   = e_rs ? 1'b0 : r_done;
    assign e_rows   = e_rs ? i_geom.height : r_rows;
    assign col_inc  = e_col + DIM_W'(1);
    assign rows_dec = e_rows - DIM_W'(1);
    assign col_sum  = {1'b0, e_col} + (DIM_W + 1)'(1);

    always_comb begin
        n_phase = e_phase;
        n_bg    = r_bg;
        n_col   = e_col;
        n_rows  = e_rows;
        n_pad   = e_pad;
        n_done  = e_done;
        n_pend  = i_restart;
        if (i_accept && !e_done) begin
            if (e_pad != '0) begin
                n_pad = e_pad - PAD_W'(1);
            end else begin
                case (e_phase)
                    bmpblit_pkg::PH_GREEN: begin
                        n_bg    = {i_data_byte, r_bg[7:0]};
                        n_phase = bmpblit_pkg::PH_RED;
                    end
                    bmpblit_pkg::PH_RED: begin
                        n_phase = bmpblit_pkg::PH_BLUE;
                        n_col   = col_inc;
                        if (col_inc >= i_geom.width) begin
                            n_col  = '0;
                            n_rows = rows_dec;
                            if (rows_dec == '0) begin
                                n_done = 1'b1;
                            end else begin
                                n_pad = i_geom.padding;
                            end
                        end
                    end
                    default: begin
                        n_bg    = {8'd0, i_data_byte};
                        n_phase = bmpblit_pkg::PH_GREEN;
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_emit            = i_accept && !e_done && (e_pad == '0)
                            && (e_phase == bmpblit_pkg::PH_RED);
        o_pixel.rows_left = e_rows;
        o_pixel.column    = e_col;
        o_pixel.word      = {i_data_byte, r_bg};
        o_pixel.last      = (e_rows == DIM_W'(1)) && (col_sum >= {1'b0, i_geom.width});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= bmpblit_pkg::PH_BLUE;
            r_col   <= '0;
            r_rows  <= '0;
            r_pad   <= '0;
            r_done  <= 1'b0;
            r_pend  <= 1'b1;
        end else begin
            r_phase <= n_phase;
            r_col   <= n_col;
            r_rows  <= n_rows;
            r_pad   <= n_pad;
            r_done  <= n_done;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg <= '0;
        end else begin
            r_bg <= n_bg;
        end
    end

    a_done_no_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_pad == '0)
        else $error("Padding pending after the image is complete.");

    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !r_pend && !i_frame_start) |-> !o_emit)
        else $error("Pixel write after the image is complete.");

endmodule

// ===== sv/bmpblit_back.sv =====
// Address stage: framebuffer address computation and the output register.
`timescale 1ns / 1ps

module bmpblit_back #(
    parameter int SCREEN_WIDTH  = bmpblit_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = bmpblit_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bmpblit_pkg::t_geom                  i_geom,
    input  bmpblit_pkg::t_pixel                 i_q_entry,
    input  logic                                i_q_empty,
    output logic                                o_q_pop,
    input  logic                                i_pop,
    output logic                                o_empty,
    output logic [bmpblit_pkg::ADDR_W-1:0]      o_fb_address,
    output logic [bmpblit_pkg::WORD_W-1:0]      o_pixel_word,
    output logic                                o_last_write
);

    localparam int ADDR_W  = bmpblit_pkg::ADDR_W;
    localparam int WORD_W  = bmpblit_pkg::WORD_W;
    localparam int ROW_W   = 13;
    localparam int PROD_W  = 2 * ROW_W;
    localparam int ROW_MID = SCREEN_HEIGHT / 2;
    localparam int COL_MID = SCREEN_WIDTH / 2;

    logic              r_valid, n_valid;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [WORD_W-1:0] r_word;
    logic              r_last;
    logic              load;
    logic [ROW_W-1:0]  row_idx;
    logic [PROD_W-1:0] row_prod;

    assign load    = !i_q_empty && (!r_valid || i_pop);
    assign o_q_pop = load;

    always_comb begin
        row_idx  = ROW_W'(ROW_MID) - ROW_W'(i_geom.height >> 1)
                   + ROW_W'(i_q_entry.rows_left) - ROW_W'(1);
        row_prod = {{ROW_W{1'b0}}, row_idx} * PROD_W'(SCREEN_WIDTH);
        n_addr   = ADDR_W'(row_prod) + ADDR_W'(COL_MID)
                   - ADDR_W'(i_geom.width >> 1) + ADDR_W'(i_q_entry.column);
    end

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_addr <= n_addr;
            r_word <= i_q_entry.word;
            r_last <= i_q_entry.last;
        end
    end

    assign o_empty      = !r_valid;
    assign o_fb_address = r_addr;
    assign o_pixel_word = r_word;
    assign o_last_write = r_last;

    a_hold_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_pop) |=> r_valid && $stable(r_addr) && $stable(r_word))
        else $error("Waiting pixel write changed before it was taken.");

endmodule

// ===== sv/bmp24_to_framebuffer_blit_unit.sv =====
// Top level of the 24-bit bottom-up BMP to 24-bit RGB framebuffer blit unit.
//
//  Channel   Handshake                 Payload
//  input     push / full               i_data_byte, i_frame_start
//  result    empty / pop               o_fb_address, o_pixel_word, o_last_write
//  config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One byte is accepted per clock while full is low; every third pixel byte yields one write.
// A write passes from the queue into the output register and is on the result ports once loaded there.
// full rises only when the two-entry queue and the output register are all
// occupied, which takes a stalled pop. Reset is synchronous, active low,
// and leaves the geometry registers at 800 x 600 with no row padding.
`timescale 1ns / 1ps

module bmp24_to_framebuffer_blit_unit #(
    parameter int SCREEN_WIDTH  = bmpblit_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = bmpblit_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [bmpblit_pkg::BYTE_W-1:0]      i_data_byte,
    input  logic                                i_frame_start,
    output logic                                empty,
    input  logic                                pop,
    output logic [bmpblit_pkg::ADDR_W-1:0]      o_fb_address,
    output logic [bmpblit_pkg::WORD_W-1:0]      o_pixel_word,
    output logic                                o_last_write,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bmpblit_pkg::INDEX_W-1:0]     i_cfg_index,
    input  logic [bmpblit_pkg::DIM_W-1:0]       i_cfg_data
);

    logic [bmpblit_pkg::DIM_W-1:0] r_width;
    logic [bmpblit_pkg::DIM_W-1:0] r_height;
    logic [bmpblit_pkg::PAD_W-1:0] r_padding;

    bmpblit_pkg::t_geom  geom;
    bmpblit_pkg::t_pixel front_pixel;
    bmpblit_pkg::t_pixel q_entry;
    logic accept;
    logic cfg_wr;
    logic restart;
    logic emit;
    logic q_full;
    logic q_empty;
    logic q_pop;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign restart     = cfg_wr && (i_cfg_index == bmpblit_pkg::REG_IMAGE_HEIGHT);
    assign accept      = push && !full;
    assign full        = q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= bmpblit_pkg::WIDTH_RST;
            r_height  <= bmpblit_pkg::HEIGHT_RST;
            r_padding <= bmpblit_pkg::PADDING_RST;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                bmpblit_pkg::REG_IMAGE_WIDTH: begin
                    r_width <= i_cfg_data;
                end
                bmpblit_pkg::REG_IMAGE_HEIGHT: begin
                    r_height <= i_cfg_data;
                end
                bmpblit_pkg::REG_ROW_PADDING: begin
                    r_padding <= i_cfg_data[bmpblit_pkg::PAD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        geom.width   = bmpblit_pkg::f_clamp(r_width, SCREEN_WIDTH);
        geom.height  = bmpblit_pkg::f_clamp(r_height, SCREEN_HEIGHT);
        geom.padding = r_padding;
    end

    bmpblit_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_data_byte   (i_data_byte),
        .i_frame_start (i_frame_start),
        .i_restart     (restart),
        .i_geom        (geom),
        .o_emit        (emit),
        .o_pixel       (front_pixel)
    );

    bmpblit_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (emit),
        .i_entry (front_pixel),
        .i_pop   (q_pop),
        .o_entry (q_entry),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    bmpblit_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_geom       (geom),
        .i_q_entry    (q_entry),
        .i_q_empty    (q_empty),
        .o_q_pop      (q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_fb_address (o_fb_address),
        .o_pixel_word (o_pixel_word),
        .o_last_write (o_last_write)
    );

endmodule
